### rtl/mcpi_pkg.sv
// Shared widths, constants, codes and types of the motor current PI controller.
package mcpi_pkg;

    // Field widths.
    localparam int MODE_W     = 3;
    localparam int MEAS_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int PCT_W      = 8;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 16;
    localparam int REF_W      = 9;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = MODE_W;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Datapath widths.
    localparam int ERR_W    = 17;
    localparam int SUM_W    = 32;
    localparam int ACC_W    = 34;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DRIVE_W  = PROD_W + 1;
    localparam int MAG_W    = 15;
    localparam int X_W      = 23;
    localparam int Q8_SHIFT = 8;

    // Division by 100 through a reciprocal: floor(2^22 / 100).
    localparam int RECIP       = 41943;
    localparam int RECIP_SHIFT = 22;
    localparam int PCT_FULL    = 100;

    localparam int FULL_DRIVE_Q8   = 25600;
    localparam int REF_MAG         = 200;
    localparam int TEST_LENGTH_DEF = 100;

    localparam logic signed [REF_W-1:0] REF_POS = REF_W'(REF_MAG);
    localparam logic signed [REF_W-1:0] REF_NEG = -REF_POS;

    // Operating modes carried on the input tuser.
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRACK = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_PCT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd3;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_ERR  = 10'b00_0000_0010,
        ST_MULP = 10'b00_0000_0100,
        ST_MULI = 10'b00_0000_1000,
        ST_MAG  = 10'b00_0001_0000,
        ST_MULD = 10'b00_0010_0000,
        ST_DIV1 = 10'b00_0100_0000,
        ST_DIV2 = 10'b00_1000_0000,
        ST_DIV3 = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } state_t;

endpackage

### rtl/mcpi_mul.sv
// Shared signed multiplier with a registered product.
module mcpi_mul
    import mcpi_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

### rtl/motor_current_pi_controller.sv
// Motor current PI controller: top level with sequencer and datapath.
// Idle, hold, track and reserved modes go straight to output; open-loop runs the duty
// multiply and divide; test mode forms the PI drive first, skipping both if saturated.
// One item is in work at a time, as the steps share the single multiplier; a new item
// is accepted only after the result has been registered.
// Reset is asynchronous: outputs invalid, control and configuration registers zero, test reference at +200 mA.
module motor_current_pi_controller
    import mcpi_pkg::*;
#(
    parameter int TEST_LENGTH = TEST_LENGTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] measured_ma
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [2:0] mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] duty_compare, [16] reverse_dir,
                                              // [25:17] reference_ma, [31:26] zero
    output logic                   m_tlast,   // test_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(TEST_LENGTH);

    state_t state_reg, state_next;

    logic signed [GAIN_W-1:0]   prop_gain_reg;
    logic signed [GAIN_W-1:0]   integ_gain_reg;
    logic signed [PCT_W-1:0]    open_pct_reg;
    logic [PERIOD_W-1:0]        pwm_period_reg;

    logic [CNT_W-1:0]           sample_count_reg;
    logic signed [SUM_W-1:0]    error_sum_reg;
    logic signed [REF_W-1:0]    test_ref_reg;
    logic [DUTY_W-1:0]          held_duty_reg;
    logic                       held_dir_reg;

    logic                       is_test_reg;
    logic signed [MEAS_W-1:0]   meas_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [X_W-1:0]             x_reg;
    logic [DUTY_W-1:0]          q0_reg;
    logic signed [REF_W-1:0]    ref_out_reg;
    logic                       done_reg;

    logic                       out_valid_reg;
    logic [DUTY_W-1:0]          out_duty_reg;
    logic                       out_dir_reg;
    logic signed [REF_W-1:0]    out_ref_reg;
    logic                       out_done_reg;

    logic                       s_accept;
    logic [MODE_W-1:0]          in_mode;
    logic signed [MEAS_W-1:0]   in_meas;
    logic [PCT_W-1:0]           pct_abs;
    logic [PCT_W-1:0]           pct_mag;
    logic                       flip;
    logic                       cnt_last;
    logic signed [REF_W-1:0]    ref_new;
    logic signed [ERR_W-1:0]    err;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [DRIVE_W-1:0]  drive;
    logic [DRIVE_W-1:0]         drive_mag;
    logic                       drive_sat;
    logic [X_W-1:0]             x_comb;
    logic [DUTY_W-1:0]          q0_comb;
    logic [X_W:0]               rem;
    logic                       q_inc;
    logic                       out_free;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_mode   = s_tuser[MODE_W-1:0];
    assign in_meas   = $signed(s_tdata[MEAS_W-1:0]);
    assign out_free  = !out_valid_reg || m_tready;

    // Open-loop percentage magnitude, limited to full drive.
    assign pct_abs = open_pct_reg[PCT_W-1] ? PCT_W'(-open_pct_reg) : PCT_W'(open_pct_reg);
    assign pct_mag = (pct_abs > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_abs;

    // Square-wave reference flips at the quarter points of the test.
    assign flip = (sample_count_reg == CNT_W'(TEST_LENGTH / 4))
               || (sample_count_reg == CNT_W'(TEST_LENGTH / 2))
               || (sample_count_reg == CNT_W'((3 * TEST_LENGTH) / 4));
    assign cnt_last = (sample_count_reg == CNT_W'(TEST_LENGTH - 1));
    assign ref_new  = flip ? -test_ref_reg : test_ref_reg;
    assign err      = ERR_W'(ref_new) - ERR_W'(meas_reg);
    assign sum_wide = (SUM_W + 1)'(error_sum_reg) + (SUM_W + 1)'(err);

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                      : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Drive in Q8 percent: the integral product arrives while the proportional one waits.
    assign drive     = DRIVE_W'(prod) + DRIVE_W'(acc_reg);
    assign drive_mag = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
    assign drive_sat = (drive_mag >= DRIVE_W'(FULL_DRIVE_Q8));

    // Closed-loop products carry the Q8 scale, which is dropped before the divide by 100.
    assign x_comb  = is_test_reg ? prod[X_W+Q8_SHIFT-1:Q8_SHIFT] : prod[X_W-1:0];
    assign q0_comb = prod[RECIP_SHIFT +: DUTY_W];
    assign rem     = {1'b0, x_reg} - prod[X_W:0];
    assign q_inc   = (rem >= (X_W + 1)'(PCT_FULL));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MULP:
            begin
                mul_a = MUL_A_W'(prop_gain_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_MULI:
            begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(integ_gain_reg);
            end
            ST_MULD:
            begin
                mul_a = $signed(MUL_A_W'(pwm_period_reg));
                mul_b = $signed(MUL_B_W'(mag_reg));
            end
            ST_DIV1:
            begin
                mul_a = $signed(MUL_A_W'(x_comb));
                mul_b = $signed(MUL_B_W'(RECIP));
            end
            ST_DIV2:
            begin
                mul_a = $signed(MUL_A_W'(q0_comb));
                mul_b = $signed(MUL_B_W'(PCT_FULL));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mcpi_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_mode)
                        MODE_OPEN: state_next = ST_MULD;
                        MODE_TEST: state_next = ST_ERR;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_ERR:  state_next = ST_MULP;
            ST_MULP: state_next = ST_MULI;
            ST_MULI: state_next = ST_MAG;
            ST_MAG:  state_next = drive_sat ? ST_OUT : ST_MULD;
            ST_MULD: state_next = ST_DIV1;
            ST_DIV1: state_next = ST_DIV2;
            ST_DIV2: state_next = ST_DIV3;
            ST_DIV3: state_next = ST_OUT;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            open_pct_reg     <= '0;
            pwm_period_reg   <= '0;
            sample_count_reg <= '0;
            error_sum_reg    <= '0;
            test_ref_reg     <= REF_POS;
            held_duty_reg    <= '0;
            held_dir_reg     <= 1'b0;
            is_test_reg      <= 1'b0;
            ref_out_reg      <= '0;
            done_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN:  prop_gain_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                    REG_INTEG_GAIN: integ_gain_reg <= $signed(cfg_data[GAIN_W-1:0]);
                    REG_OPEN_PCT:   open_pct_reg   <= $signed(cfg_data[PCT_W-1:0]);
                    REG_PWM_PERIOD: pwm_period_reg <= cfg_data[PERIOD_W-1:0];
                    default:        ;
                endcase
            end

            if (s_accept)
            begin
                is_test_reg <= (in_mode == MODE_TEST);
                ref_out_reg <= '0;
                done_reg    <= 1'b0;
                case (in_mode)
                    MODE_IDLE: held_duty_reg <= '0;
                    MODE_OPEN: held_dir_reg  <= open_pct_reg[PCT_W-1];
                    default:   ;
                endcase
            end

            if (state_reg == ST_ERR)
            begin
                test_ref_reg  <= ref_new;
                ref_out_reg   <= ref_new;
                done_reg      <= cnt_last;
                error_sum_reg <= cnt_last ? '0 : sum_sat;
                sample_count_reg <= cnt_last ? '0 : sample_count_reg + CNT_W'(1);
            end

            if (state_reg == ST_MAG)
            begin
                held_dir_reg <= drive[DRIVE_W-1];
                if (drive_sat)
                begin
                    held_duty_reg <= pwm_period_reg;
                end
            end

            if (state_reg == ST_DIV3)
            begin
                held_duty_reg <= q0_reg + DUTY_W'(q_inc);
            end

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the datapath and the output stage.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            meas_reg <= in_meas;
            mag_reg  <= MAG_W'(pct_mag);
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= err;
            sum_reg <= sum_sat;
        end
        if (state_reg == ST_MULI)
        begin
            acc_reg <= prod[ACC_W-1:0];
        end
        if (state_reg == ST_MAG)
        begin
            mag_reg <= drive_mag[MAG_W-1:0];
        end
        if (state_reg == ST_DIV1)
        begin
            x_reg <= x_comb;
        end
        if (state_reg == ST_DIV2)
        begin
            q0_reg <= q0_comb;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_duty_reg <= held_duty_reg;
            out_dir_reg  <= held_dir_reg;
            out_ref_reg  <= ref_out_reg;
            out_done_reg <= done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {(OUT_TDATA_W - DUTY_W - 1 - REF_W)'(0), out_ref_reg, out_dir_reg,
                       out_duty_reg};

endmodule

### rtl/mcpi_checker.sv
// Port-level checks of the motor current PI controller and their bind.
module mcpi_checker
    import mcpi_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    logic [REF_W-1:0] out_ref;

    assign out_ref = m_tdata[DUTY_W+REF_W:DUTY_W+1];

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The sequencer is busy in the cycle after it takes an item.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // The reference reported is zero outside test mode and otherwise plus or minus 200 mA.
    a_ref_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_ref == '0) || (out_ref == REF_POS) || (out_ref == REF_NEG))
        else $error("reference out of range");

    // The end of a test is a test sample, so it carries a nonzero reference.
    a_done_ref: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (out_ref == REF_POS) || (out_ref == REF_NEG))
        else $error("test done without a test reference");

endmodule

bind motor_current_pi_controller mcpi_checker u_mcpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

### tb/tb_motor_current_pi_controller.sv
// Self-checking testbench for the motor current PI controller stream block.
module tb_motor_current_pi_controller
    import mcpi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEST_LEN      = TEST_LENGTH_DEF;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 40;
    localparam int N_REGS        = 1 << CFG_IDX_W;

    // Mode codes that the block treats like hold.
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    typedef struct packed {
        logic                    done;
        logic signed [REF_W-1:0] ref_ma;
        logic                    rev;
        logic [DUTY_W-1:0]       duty;
    } tick_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [MODE_W-1:0]     mode;
        logic [MEAS_W-1:0]     meas;
        bit                    typed;
        tick_result_t          want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Controller state as the predictor sees it.
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [PCT_W-1:0]  open_pct;
    logic [PERIOD_W-1:0]      period;
    int                       sample_idx;
    longint                   err_integral;
    int                       ref_now;
    logic [DUTY_W-1:0]        last_duty;
    logic                     last_rev;

    tick_result_t pending_ticks[$];
    stim_row_t    directed_rows[$];
    int           n_errors;
    int           n_reports;
    bit           no_gaps;

    logic [MODE_W-1:0] off_test_modes[7] = '{MODE_IDLE, MODE_OPEN, MODE_HOLD, MODE_TRACK,
                                            MODE_RSVD5, MODE_RSVD6, MODE_RSVD7};

    motor_current_pi_controller #(.TEST_LENGTH(TEST_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the result of one control tick and advances the controller state.
    function automatic tick_result_t compute_tick(input logic [MODE_W-1:0] mode,
                                                  input logic [MEAS_W-1:0] meas);
        tick_result_t r;
        longint pct, pct_mag, per, meas_v, err, sum, drive, mag;
        r      = '0;
        per    = period;
        meas_v = $signed(meas);
        case (mode)
            MODE_IDLE: last_duty = '0;
            MODE_OPEN:
            begin
                pct     = open_pct;
                pct_mag = (pct < 0) ? -pct : pct;
                if (pct_mag > PCT_FULL)
                    pct_mag = PCT_FULL;
                last_rev  = (pct < 0);
                last_duty = DUTY_W'((pct_mag * per) / PCT_FULL);
            end
            MODE_TEST:
            begin
                if (sample_idx == TEST_LEN / 4 || sample_idx == TEST_LEN / 2 ||
                    sample_idx == (3 * TEST_LEN) / 4)
                    ref_now = -ref_now;
                r.ref_ma = REF_W'(ref_now);
                err = ref_now - meas_v;
                sum = err_integral + err;
                if (sum > longint'(32'sh7FFF_FFFF))
                    sum = longint'(32'sh7FFF_FFFF);
                if (sum < -longint'(32'sh7FFF_FFFF) - 1)
                    sum = -longint'(32'sh7FFF_FFFF) - 1;
                err_integral = sum;
                drive = longint'(gain_p) * err + longint'(gain_i) * err_integral;
                last_rev = (drive < 0);
                mag = (drive < 0) ? -drive : drive;
                if (mag >= FULL_DRIVE_Q8)
                    last_duty = period;
                else
                    last_duty = DUTY_W'((mag * per) / FULL_DRIVE_Q8);
                sample_idx++;
                if (sample_idx >= TEST_LEN)
                begin
                    r.done       = 1'b1;
                    sample_idx   = 0;
                    err_integral = 0;
                end
            end
            default: ;
        endcase
        r.duty = last_duty;
        r.rev  = last_rev;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.mode  = '0;
        row.meas  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic [MODE_W-1:0] mode,
                                     input logic [MEAS_W-1:0] meas, input bit typed,
                                     input logic [DUTY_W-1:0] duty, input logic rev,
                                     input logic [REF_W-1:0] ref_ma, input logic done);
        stim_row_t row;
        row.kind  = ROW_ITEM;
        row.idx   = '0;
        row.data  = '0;
        row.mode  = mode;
        row.meas  = meas;
        row.typed = typed;
        row.want  = '{done: done, ref_ma: ref_ma, rev: rev, duty: duty};
        directed_rows.push_back(row);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] gain_value(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h7FFF;
        if (r == 1)
            return 16'h8000;
        if (r == 2)
            return '0;
        return CFG_DATA_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_value_for(input logic [CFG_IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 9);
        case (idx)
            REG_PROP_GAIN:  return gain_value(1024);
            REG_INTEG_GAIN: return gain_value(64);
            REG_OPEN_PCT:
            begin
                if (r == 0)
                    return 16'hFF80;
                if (r == 1)
                    return 16'h007F;
                if (r == 2)
                    return $urandom_range(0, 1) ? 16'hFF9C : 16'h0064;
                return CFG_DATA_W'(int'($urandom_range(0, 200)) - 100);
            end
            default:
            begin
                if (r == 0)
                    return '0;
                if (r == 1)
                    return 16'hFFFF;
                return CFG_DATA_W'($urandom);
            end
        endcase
    endfunction

    // Mostly a current that follows the reference, now and then anything at all.
    function automatic logic [MEAS_W-1:0] meas_near_ref();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return MEAS_W'(ref_now + int'($urandom_range(0, 800)) - 400);
        if (r < 90)
            return MEAS_W'($urandom);
        if (r < 95)
            return 16'h7FFF;
        return 16'h8000;
    endfunction

    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PROP_GAIN:  gain_p   = data;
            REG_INTEG_GAIN: gain_i   = data;
            REG_OPEN_PCT:   open_pct = data[PCT_W-1:0];
            default:        period   = data;
        endcase
    endtask

    // Leaves s_tvalid high so that the next item can follow without a gap.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [MEAS_W-1:0] meas,
                             input bit typed, input tick_result_t want);
        int gap;
        tick_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = compute_tick(mode, meas);
        pending_ticks.push_back(typed ? want : predicted);
    endtask

    task automatic report_mismatch(input string field, input longint want, input longint got);
        n_errors++;
        if (n_reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        n_reports++;
    endtask

    task automatic check_result();
        tick_result_t want;
        if (pending_ticks.size() == 0)
        begin
            n_errors++;
            if (n_reports < MAX_REPORTS)
                $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
            n_reports++;
        end
        else
        begin
            want = pending_ticks.pop_front();
            if (m_tdata[DUTY_W-1:0] !== want.duty)
                report_mismatch("duty_compare", want.duty, m_tdata[DUTY_W-1:0]);
            if (m_tdata[DUTY_W] !== want.rev)
                report_mismatch("reverse_dir", want.rev, m_tdata[DUTY_W]);
            if (m_tdata[DUTY_W+REF_W:DUTY_W+1] !== want.ref_ma)
                report_mismatch("reference_ma", want.ref_ma, m_tdata[DUTY_W+REF_W:DUTY_W+1]);
            if (m_tdata[OUT_TDATA_W-1:DUTY_W+REF_W+1] !== '0)
                report_mismatch("tdata padding", 0, m_tdata[OUT_TDATA_W-1:DUTY_W+REF_W+1]);
            if (m_tlast !== want.done)
                report_mismatch("test_done", want.done, m_tlast);
        end
    endtask

    // Result side: takes results and stalls at random.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Ends a run in which no transaction happens for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int n_items;
        int len;
        bit first_phase;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        gain_p       = '0;
        gain_i       = '0;
        open_pct     = '0;
        period       = '0;
        sample_idx   = 0;
        err_integral = 0;
        ref_now      = REF_MAG;
        last_duty    = '0;
        last_rev     = 1'b0;
        n_errors     = 0;
        n_reports    = 0;
        no_gaps      = 1'b0;

        // After reset every gain and the period are zero, so every duty is zero.
        add_item(MODE_IDLE,  16'h0000, 1, 16'h0000, 1'b0, '0, 1'b0);
        add_item(MODE_HOLD,  16'h7FFF, 1, 16'h0000, 1'b0, '0, 1'b0);
        add_item(MODE_TEST,  16'h8000, 1, 16'h0000, 1'b0, REF_POS, 1'b0);
        add_item(MODE_OPEN,  16'h0000, 1, 16'h0000, 1'b0, '0, 1'b0);
        // A percentage beyond full scale saturates at full duty.
        add_cfg(REG_PWM_PERIOD, 16'hFFFF);
        add_cfg(REG_OPEN_PCT,   16'hFF80);
        add_item(MODE_OPEN,  16'h0000, 1, 16'hFFFF, 1'b1, '0, 1'b0);
        add_item(MODE_TRACK, 16'hFFFF, 1, 16'hFFFF, 1'b1, '0, 1'b0);
        add_item(MODE_RSVD5, 16'h1234, 1, 16'hFFFF, 1'b1, '0, 1'b0);
        add_item(MODE_RSVD7, 16'h8001, 1, 16'hFFFF, 1'b1, '0, 1'b0);
        // Idle clears the duty but keeps the direction.
        add_item(MODE_IDLE,  16'h0001, 1, 16'h0000, 1'b1, '0, 1'b0);
        add_cfg(REG_OPEN_PCT, 16'h007F);
        add_item(MODE_OPEN,  16'h0000, 1, 16'hFFFF, 1'b0, '0, 1'b0);
        add_cfg(REG_OPEN_PCT, 16'h0001);
        add_item(MODE_OPEN,  16'h0000, 1, 16'd655,  1'b0, '0, 1'b0);
        add_cfg(REG_OPEN_PCT, 16'hFF9C);
        add_item(MODE_OPEN,  16'h0000, 1, 16'hFFFF, 1'b1, '0, 1'b0);
        add_cfg(REG_PROP_GAIN,  16'h7FFF);
        add_cfg(REG_INTEG_GAIN, 16'h8000);
        add_item(MODE_TEST,  16'h0000, 0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_TEST,  16'h7FFF, 0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_TEST,  16'h8000, 0, '0, 1'b0, '0, 1'b0);
        add_cfg(REG_PROP_GAIN,  16'h8000);
        add_cfg(REG_INTEG_GAIN, 16'h7FFF);
        add_item(MODE_TEST,  16'h8000, 0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_TEST,  16'd200,  0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_HOLD,  16'h0000, 0, '0, 1'b0, '0, 1'b0);
        // Small gains keep the drive below saturation.
        add_cfg(REG_PWM_PERIOD, 16'd100);
        add_cfg(REG_PROP_GAIN,  16'h0100);
        add_cfg(REG_INTEG_GAIN, 16'h0000);
        add_item(MODE_TEST,  16'd199,  0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_TEST,  16'd210,  0, '0, 1'b0, '0, 1'b0);
        add_cfg(REG_PWM_PERIOD, 16'h0000);
        add_item(MODE_TEST,  16'h1234, 0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_RSVD6, 16'h5555, 0, '0, 1'b0, '0, 1'b0);
        add_item(MODE_IDLE,  16'hAAAA, 0, '0, 1'b0, '0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CFG)
                    wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
                if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end
            else
                send_item(directed_rows[i].mode, directed_rows[i].meas,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: new settings, then mostly test runs with a tracking current,
        // sometimes interrupted, and now and then plain noise.
        n_items     = 0;
        first_phase = 1'b1;
        while (n_items < RANDOM_ITEMS)
        begin
            wait_idle();
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int r = 0; r < N_REGS; r++)
                if (first_phase || $urandom_range(0, 9) < 6)
                    write_reg(CFG_IDX_W'(r), reg_value_for(CFG_IDX_W'(r)));
            cfg_valid  <= 1'b0;
            first_phase = 1'b0;
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(20, 130);
                repeat (len)
                begin
                    if ($urandom_range(0, 99) < 8)
                        send_item(off_test_modes[$urandom_range(0, 6)], MEAS_W'($urandom),
                                  0, '0);
                    else
                        send_item(MODE_TEST, meas_near_ref(), 0, '0);
                    n_items++;
                end
            end
            else
            begin
                len = $urandom_range(5, 30);
                repeat (len)
                begin
                    send_item(MODE_W'($urandom_range(0, 7)), MEAS_W'($urandom), 0, '0);
                    n_items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
